### rtl/srhd_pkg.sv
// Package for the scan region hit detector: sizes, mode and status codes,
// and the quarter-wave sine table built at elaboration.
// No dependencies.
package srhd_pkg;

  // Box table depth and sine table resolution
  localparam int MAX_BOXES       = 8;
  localparam int SINE_TABLE_BITS = 10;

  // Mask width of a scan report, and the boxes that can set a mask bit
  localparam int HIT_BITS   = 8;
  localparam int MASK_BOXES = (MAX_BOXES < HIT_BITS) ? MAX_BOXES : HIT_BITS;

  // Box count width, wide enough to hold MAX_BOXES itself
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  // Quarter-wave table geometry
  localparam int QTR_BITS   = SINE_TABLE_BITS - 2;
  localparam int QUARTER    = 1 << QTR_BITS;
  localparam int STEP_SHIFT = 18 - SINE_TABLE_BITS;

  // Table index step for a ninety degree turn
  localparam logic [SINE_TABLE_BITS-1:0] QUARTER_STEP = SINE_TABLE_BITS'(QUARTER);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SCAN  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_REPORT    = 2'd0,
    STATUS_ACCEPTED  = 2'd1,
    STATUS_ZERO_SIZE = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef logic [15:0] quarter_tab_t [QUARTER];

  // Polynomial sine on a quarter turn, x in Q16, result in Q15 (elaboration only)
  function automatic logic [15:0] quarter_poly(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    x2 = (x * x) >> 16;
    t  = 64'd42047 - ((x2 * 64'd4640) >> 16);
    t2 = 64'd102944 - ((x2 * t) >> 16);
    p  = (x * t2) >> 17;
    return (p > 64'd32768) ? 16'd32768 : p[15:0];
  endfunction

  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t tab;
    for (int i = 0; i < QUARTER; i++) begin
      tab[i] = quarter_poly(64'(i) << STEP_SHIFT);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_TAB  = build_quarter_tab();
  localparam logic [15:0]  QUARTER_FULL = quarter_poly(64'd65536);

  // Table sine of a truncated angle index, Q15, range -32768..32768
  function automatic logic signed [16:0] sine_lookup(logic [SINE_TABLE_BITS-1:0] k);
    logic [1:0]          q;
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS-1:0] rev;
    logic [15:0]         mag;
    q   = k[SINE_TABLE_BITS-1 -: 2];
    r   = k[QTR_BITS-1:0];
    rev = ~r + 1'b1;
    // Odd quadrants run the table backward; the peak sits past its end
    if (q[0]) begin
      mag = (r == '0) ? QUARTER_FULL : QUARTER_TAB[rev];
    end else begin
      mag = QUARTER_TAB[r];
    end
    return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

### rtl/scan_region_hit_detector.sv
// Scan region hit detector top level: point conversion, box table and
// hit accumulation in a three-register pipeline. Depends on srhd_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_stall    | mode distance beam_angle last_point box_*
//  out      | out_valid / out_stall  | hit_mask box_count status
//  cfg      | cfg_valid / cfg_ready  | cfg_data (rotation_offset)
//
// One item per cycle while in_stall is low. The transfer loads the input register,
// then the coordinate register behind a 17x17 and a 17x18 multiply, then the result
// register.
// Reset empties the box table and the hit mask at once; box bounds are not cleared.
// out_stall holds the result register; items with no result keep retiring and the
// input side stalls only when both inner stages are full behind a held result.
module scan_region_hit_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] distance,
  input  logic [15:0] beam_angle,
  input  logic        last_point,
  input  logic signed [16:0] box_left,
  input  logic signed [16:0] box_top,
  input  logic signed [16:0] box_width,
  input  logic signed [16:0] box_height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  hit_mask,
  output logic [3:0]  box_count,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int STB   = srhd_pkg::SINE_TABLE_BITS;
  localparam int CNT_W = srhd_pkg::CNT_W;
  localparam int MASKB = srhd_pkg::MASK_BOXES;

  typedef struct packed {
    logic signed [17:0] lo;
    logic signed [17:0] hi;
  } bounds_t;

  // Configuration register
  logic [15:0] rotation_offset;

  // Input register
  logic               s1_valid;
  logic [1:0]         s1_mode;
  logic [15:0]        s1_distance;
  logic [15:0]        s1_beam_angle;
  logic               s1_last;
  logic signed [16:0] s1_left;
  logic signed [16:0] s1_top;
  logic signed [16:0] s1_width;
  logic signed [16:0] s1_height;

  // Coordinate register
  logic               s2_valid;
  logic [1:0]         s2_mode;
  logic               s2_last;
  logic signed [17:0] s2_px;
  logic signed [17:0] s2_py;
  logic               s2_zero;
  bounds_t            s2_bx;
  bounds_t            s2_by;

  // Box table and scan state
  bounds_t            box_x [MASKB];
  bounds_t            box_y [MASKB];
  logic [CNT_W-1:0]   count;
  logic [7:0]         acc;

  // Pipeline control
  logic out_free;
  logic s2_needs_out;
  logic s2_adv;
  logic s2_retire;
  logic s1_adv;

  assign out_free     = !out_valid || !out_stall;
  assign s2_needs_out = (s2_mode == srhd_pkg::MODE_ADD) ||
                        ((s2_mode == srhd_pkg::MODE_SCAN) && s2_last);
  assign s2_adv       = !s2_needs_out || out_free;
  assign s2_retire    = s2_valid && s2_adv;
  assign s1_adv       = !s2_valid || s2_adv;
  assign in_stall     = s1_valid && !s1_adv;
  assign cfg_ready    = 1'b1;

  // Take a configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_offset <= 16'd16384;
    end else if (cfg_valid) begin
      rotation_offset <= cfg_data;
    end
  end

  // Capture an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode       <= mode;
      s1_distance   <= distance;
      s1_beam_angle <= beam_angle;
      s1_last       <= last_point;
      s1_left       <= box_left;
      s1_top        <= box_top;
      s1_width      <= box_width;
      s1_height     <= box_height;
    end
  end

  // Turn the beam, look up sine and cosine, scale by distance
  logic [15:0]          angle;
  logic [STB-1:0]       k_sin;
  logic [STB-1:0]       k_cos;
  logic signed [16:0]   sin_val;
  logic signed [16:0]   cos_val;
  logic signed [17:0]   neg_sin;
  logic signed [33:0]   prod_x;
  logic signed [34:0]   prod_y;

  always_comb begin
    angle   = s1_beam_angle + rotation_offset;
    k_sin   = angle[15 -: STB];
    k_cos   = k_sin + srhd_pkg::QUARTER_STEP;
    sin_val = srhd_pkg::sine_lookup(k_sin);
    cos_val = srhd_pkg::sine_lookup(k_cos);
    neg_sin = -$signed({sin_val[16], sin_val});
    prod_x  = $signed({1'b0, s1_distance}) * cos_val;
    prod_y  = $signed({1'b0, s1_distance}) * neg_sin;
  end

  // Normalize a box to inclusive low/high bounds
  logic signed [17:0] x_ext;
  logic signed [17:0] y_ext;
  logic signed [17:0] x_sum;
  logic signed [17:0] y_sum;
  bounds_t            bx_next;
  bounds_t            by_next;

  always_comb begin
    x_ext = $signed({s1_left[16], s1_left});
    y_ext = $signed({s1_top[16], s1_top});
    x_sum = x_ext + $signed({s1_width[16], s1_width});
    y_sum = y_ext + $signed({s1_height[16], s1_height});
    bx_next.lo = s1_width[16]  ? x_sum : x_ext;
    bx_next.hi = s1_width[16]  ? x_ext : x_sum;
    by_next.lo = s1_height[16] ? y_sum : y_ext;
    by_next.hi = s1_height[16] ? y_ext : y_sum;
  end

  // Advance the coordinate register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_mode <= s1_mode;
      s2_last <= s1_last;
      // Arithmetic shift by 15 is the floor division; the value fits 18 bits
      s2_px   <= prod_x[32:15];
      s2_py   <= prod_y[32:15];
      s2_zero <= (s1_width == '0) || (s1_height == '0);
      s2_bx   <= bx_next;
      s2_by   <= by_next;
    end
  end

  // Test the point against every stored box
  logic [7:0] hits;
  logic       full;
  logic       add_ok;

  always_comb begin
    hits = '0;
    for (int j = 0; j < MASKB; j++) begin
      hits[j] = (CNT_W'(j) < count) &&
                (box_x[j].lo <= s2_px) && (s2_px <= box_x[j].hi) &&
                (box_y[j].lo <= s2_py) && (s2_py <= box_y[j].hi);
    end
    full   = (count == CNT_W'(srhd_pkg::MAX_BOXES));
    add_ok = !s2_zero && !full;
  end

  // Form the result of an add or of the last point of a scan
  logic [7:0]          mask_next;
  logic [CNT_W-1:0]    count_after;
  srhd_pkg::status_t   status_next;

  always_comb begin
    mask_next   = '0;
    count_after = count;
    status_next = srhd_pkg::STATUS_REPORT;
    if (s2_mode == srhd_pkg::MODE_ADD) begin
      if (s2_zero) begin
        status_next = srhd_pkg::STATUS_ZERO_SIZE;
      end else if (full) begin
        status_next = srhd_pkg::STATUS_FULL;
      end else begin
        status_next = srhd_pkg::STATUS_ACCEPTED;
        count_after = count + 1'b1;
      end
    end else begin
      mask_next = acc | hits;
    end
  end

  // Update box count and hit mask as an item retires
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      acc   <= '0;
    end else if (s2_retire) begin
      case (s2_mode)
        srhd_pkg::MODE_CLEAR: begin
          count <= '0;
          acc   <= '0;
        end
        srhd_pkg::MODE_ADD: begin
          count <= count_after;
        end
        srhd_pkg::MODE_SCAN: begin
          acc <= s2_last ? 8'd0 : (acc | hits);
        end
        default: begin
        end
      endcase
    end
  end

  // Write an accepted box into the next free entry
  always_ff @(posedge clk) begin
    for (int j = 0; j < MASKB; j++) begin
      if (s2_retire && (s2_mode == srhd_pkg::MODE_ADD) && add_ok &&
          (count == CNT_W'(j))) begin
        box_x[j] <= s2_bx;
        box_y[j] <= s2_by;
      end
    end
  end

  // Load the result register; drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_retire && s2_needs_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_retire && s2_needs_out) begin
      hit_mask  <= mask_next;
      box_count <= 4'(count_after);
      status    <= status_next;
    end
  end

endmodule

### rtl/srhd_checker.sv
// Port-level checks for the scan region hit detector, bound to the top level.
// Depends on srhd_pkg and scan_region_hit_detector.
module srhd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] hit_mask,
  input logic [3:0] box_count,
  input logic [1:0] status
);

  // No result survives reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result until its transfer
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit_mask) &&
                               $stable(box_count) && $stable(status))
    else $error("stalled result changed");

  // Add results never carry hits
  a_add_no_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != srhd_pkg::STATUS_REPORT) |-> hit_mask == 8'd0)
    else $error("add result with a nonzero hit mask");

  // A full table reports the full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == srhd_pkg::STATUS_FULL) |->
      box_count == 4'(srhd_pkg::MAX_BOXES))
    else $error("table full with a count short of the depth");

endmodule

bind scan_region_hit_detector srhd_checker u_srhd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit_mask  (hit_mask),
  .box_count (box_count),
  .status    (status)
);
